[src/mafs_pkg.sv]
// Shared types, tables and constants for the MPEG audio frame synchroniser.
// Used by the controller, the datapath, the top level and the checker.
// No dependencies.
package mafs_pkg;

  localparam int unsigned QUO_W     = 12;  // quotient bits of the frame length divide
  localparam int unsigned DIV_STEPS = QUO_W;
  localparam int unsigned DCNT_W    = $clog2(DIV_STEPS);
  localparam int unsigned DVD_W     = 27;  // bitrate times frame constant
  localparam int unsigned DSR_W     = 17;  // sample rate, doubled for low rates in layer 3

  localparam logic [31:0] SYNC_MASK  = 32'hffe00000;
  localparam logic [17:0] L1_FACTOR  = 18'd12000;
  localparam logic [17:0] L23_FACTOR = 18'd144000;
  localparam logic [10:0] LEN_MAX    = 11'd2047;

  localparam logic [8:0] KBPS [0:1][0:2][0:14] = '{
    '{ '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
         9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448},
       '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
         9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384},
       '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
         9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320} },
    '{ '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
         9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256},
       '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
         9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160},
       '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
         9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160} }
  };

  localparam logic [15:0] HZ [0:8] = '{
    16'd44100, 16'd48000, 16'd32000, 16'd22050, 16'd24000,
    16'd16000, 16'd11025, 16'd12000, 16'd8000
  };

  localparam logic [1:0] VER_MPEG1  = 2'd0;
  localparam logic [1:0] VER_MPEG2  = 2'd1;
  localparam logic [1:0] VER_MPEG25 = 2'd2;

  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_SEEK = 1'b1;

  localparam logic KIND_HEADER  = 1'b0;
  localparam logic KIND_PAYLOAD = 1'b1;

  typedef struct packed {
    logic       action;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    logic        last_of_frame;
    logic        skipped;
    logic [31:0] header_word;
    logic [1:0]  layer;
    logic [1:0]  version_code;
    logic [3:0]  rate_index;
    logic [10:0] frame_len;
    logic [5:0]  side_info_len;
    logic        crc_present;
    logic        mono;
  } out_item_t;

  typedef enum logic [1:0] {
    S_SCAN,
    S_MUL,
    S_DIV,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic take_byte;
    logic mul_load;
    logic div_step;
    logic emit_hdr;
  } dp_cmd_t;

  typedef struct packed {
    logic hdr_hit;
    logic out_valid;
  } dp_status_t;

endpackage

[src/mpeg_audio_frame_sync.sv]
// Top level of the MPEG audio frame synchroniser.
// Joins mafs_ctrl and mafs_datapath; types from mafs_pkg.
//
//  channel  direction  handshake          payload
//  in       input      in_valid/in_stall  in_item_t (action, data_byte)
//  out      output     out_valid/out_stall out_item_t (header or payload result)
//  cfg      input      cfg_valid/cfg_ready frames_to_skip, 3 bits
//
// Payload, seek and header-search bytes leave the controller ready for more.
// The fourth byte of a good header starts the multiply, 12 restoring-divide
// steps for the frame length, and the header request, which waits on the output.
// Reset is synchronous; frames_to_skip returns to 3 and the search restarts.
// A held output request stalls the input; cfg writes are always taken.
module mpeg_audio_frame_sync import mafs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [2:0] cfg_data
);

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  mafs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  mafs_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

[src/mafs_ctrl.sv]
// Controller for the frame synchroniser: sequences byte intake, the length
// multiply, the iterative divide and the header request. Uses mafs_pkg.
module mafs_ctrl import mafs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       out_stall,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t              state, state_next;
  logic [DCNT_W-1:0]   div_cnt, div_cnt_next;
  logic                out_busy;

  assign out_busy = status.out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_SCAN;
      div_cnt <= '0;
    end else begin
      state   <= state_next;
      div_cnt <= div_cnt_next;
    end
  end

  always_comb begin
    state_next   = state;
    div_cnt_next = div_cnt;
    cmd          = '0;
    in_stall     = 1'b1;
    unique case (state)
      S_SCAN: begin
        in_stall      = out_busy;
        cmd.take_byte = in_valid && !out_busy;
        if (cmd.take_byte && status.hdr_hit) begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_load = 1'b1;
        div_cnt_next = '0;
        state_next   = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (div_cnt == DCNT_W'(DIV_STEPS - 1)) begin
          state_next = S_EMIT;
        end else begin
          div_cnt_next = div_cnt + 1'b1;
        end
      end
      S_EMIT: begin
        // hold until the output register is free
        if (!out_busy) begin
          cmd.emit_hdr = 1'b1;
          state_next   = S_SCAN;
        end
      end
      default: state_next = S_SCAN;
    endcase
  end

endmodule

[src/mafs_datapath.sv]
// Datapath for the frame synchroniser: header window, header decode, length
// multiply and restoring divide, frame counters and the output register.
// Uses mafs_pkg; driven by mafs_ctrl.
module mafs_datapath import mafs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  in_item_t   in_data,
  input  logic       cfg_valid,
  input  logic [2:0] cfg_data,
  input  logic       out_stall,
  input  dp_cmd_t    cmd,
  output dp_status_t status,
  output logic       out_valid,
  output out_item_t  out_data
);

  logic [2:0]        frames_to_skip;
  logic [23:0]       header_window;
  logic [1:0]        header_fill;
  logic              in_frame;
  logic [10:0]       payload_length;
  logic [10:0]       payload_count;
  logic [2:0]        skip_count;
  logic              current_skipped;
  logic [31:0]       hdr;
  logic [DVD_W-1:0]  rem;
  logic [DVD_W:0]    dsr;
  logic [QUO_W-1:0]  quo;

  // header check on the window plus the incoming byte
  logic [31:0] cand;
  logic        cand_ok;
  logic        is_seek;
  logic        is_payload;

  assign cand    = {header_window, in_data.data_byte};
  assign cand_ok = ((cand & SYNC_MASK) == SYNC_MASK) && (cand[18:17] != 2'd0)
                   && (cand[15:12] != 4'd0) && (cand[15:12] != 4'hf)
                   && (cand[11:10] != 2'd3);
  assign is_seek    = (in_data.action == ACT_SEEK);
  assign is_payload = !is_seek && in_frame;

  assign status.hdr_hit   = !is_seek && !in_frame && (header_fill == 2'd3) && cand_ok;
  assign status.out_valid = out_valid;

  // decode of the held header
  logic             lsf;
  logic [1:0]       ver;
  logic [3:0]       rix;
  logic [1:0]       lay;
  logic [1:0]       lay_idx;
  logic [3:0]       br;
  logic             pad;
  logic             crc;
  logic             mono;
  logic [DSR_W-1:0] divisor;
  logic [17:0]      factor;
  logic [5:0]       side;

  always_comb begin
    if (hdr[20]) begin
      lsf = ~hdr[19];
      ver = lsf ? VER_MPEG2 : VER_MPEG1;
      rix = {2'b00, hdr[11:10]} + (lsf ? 4'd3 : 4'd0);
    end else begin
      lsf = 1'b1;
      ver = VER_MPEG25;
      rix = 4'd6 + {2'b00, hdr[11:10]};
    end
    lay_idx = ~hdr[18:17];
    lay     = lay_idx + 2'd1;
    br      = hdr[15:12];
    pad     = hdr[9];
    crc     = ~hdr[16];
    mono    = (hdr[7:6] == 2'd3);
    factor  = (lay == 2'd1) ? L1_FACTOR : L23_FACTOR;
    if (lay == 2'd3 && lsf) begin
      divisor = {HZ[rix], 1'b0};
    end else begin
      divisor = {1'b0, HZ[rix]};
    end
    side = 6'd0;
    if (lay == 2'd3) begin
      if (lsf) side = mono ? 6'd9 : 6'd17;
      else     side = mono ? 6'd17 : 6'd32;
      if (crc) side = side + 6'd2;
    end
  end

  // frame length from the quotient
  logic [13:0] len_wide;
  logic [10:0] len_sat;

  always_comb begin
    if (lay == 2'd1) begin
      len_wide = {quo, 2'b00} + {11'd0, pad, 2'b00} - 14'd4;
    end else begin
      len_wide = {2'b00, quo} + {13'd0, pad} - 14'd4;
    end
    len_sat = (len_wide > {3'd0, LEN_MAX}) ? LEN_MAX : len_wide[10:0];
  end

  logic [DVD_W:0] rem_ext;
  logic [10:0]    count_inc;
  logic           frame_end;

  assign rem_ext   = {1'b0, rem};
  assign count_inc = payload_count + 11'd1;
  assign frame_end = (count_inc >= payload_length);

  // result items for the two kinds of request
  out_item_t pay_item;
  out_item_t hdr_item;
  logic      out_set;

  always_comb begin
    pay_item               = '0;
    pay_item.kind          = KIND_PAYLOAD;
    pay_item.payload_byte  = in_data.data_byte;
    pay_item.last_of_frame = frame_end;
    pay_item.skipped       = current_skipped;

    hdr_item               = '0;
    hdr_item.kind          = KIND_HEADER;
    hdr_item.skipped       = current_skipped;
    hdr_item.header_word   = hdr;
    hdr_item.layer         = lay;
    hdr_item.version_code  = ver;
    hdr_item.rate_index    = rix;
    hdr_item.frame_len     = len_sat;
    hdr_item.side_info_len = side;
    hdr_item.crc_present   = crc;
    hdr_item.mono          = mono;
  end

  assign out_set = (cmd.take_byte && is_payload) || cmd.emit_hdr;

  always_ff @(posedge clk) begin
    if (rst) begin
      frames_to_skip  <= 3'd3;
      header_window   <= '0;
      header_fill     <= '0;
      in_frame        <= 1'b0;
      payload_length  <= '0;
      payload_count   <= '0;
      skip_count      <= '0;
      current_skipped <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_valid) frames_to_skip <= cfg_data;

      // hold a stalled request, drop a taken one unless a new one arrives
      out_valid <= out_set || (out_valid && out_stall);

      if (cmd.take_byte) begin
        if (is_seek) begin
          header_window   <= '0;
          header_fill     <= '0;
          in_frame        <= 1'b0;
          payload_length  <= '0;
          payload_count   <= '0;
          current_skipped <= 1'b0;
          skip_count      <= frames_to_skip;
        end else if (in_frame) begin
          if (frame_end) begin
            in_frame      <= 1'b0;
            header_fill   <= '0;
            header_window <= '0;
            payload_count <= '0;
          end else begin
            payload_count <= count_inc;
          end
        end else if (header_fill != 2'd3) begin
          header_window <= cand[23:0];
          header_fill   <= header_fill + 2'd1;
        end else if (cand_ok) begin
          header_window   <= '0;
          header_fill     <= '0;
          in_frame        <= 1'b1;
          payload_count   <= '0;
          current_skipped <= (skip_count != 3'd0);
          if (skip_count != 3'd0) skip_count <= skip_count - 3'd1;
        end else begin
          // slide by one byte
          header_window <= cand[23:0];
        end
      end

      if (cmd.emit_hdr) begin
        payload_length <= len_sat;
      end
    end
  end

  // payload registers: header latch, divider and output item
  always_ff @(posedge clk) begin
    if (cmd.take_byte && status.hdr_hit) begin
      hdr <= cand;
    end
    if (cmd.mul_load) begin
      rem <= DVD_W'(KBPS[lsf][lay_idx][br] * factor);
      dsr <= {divisor, {(QUO_W-1){1'b0}}};
      quo <= '0;
    end else if (cmd.div_step) begin
      if (rem_ext >= dsr) begin
        rem <= DVD_W'(rem_ext - dsr);
        quo <= {quo[QUO_W-2:0], 1'b1};
      end else begin
        quo <= {quo[QUO_W-2:0], 1'b0};
      end
      dsr <= dsr >> 1;
    end

    if (cmd.take_byte && is_payload) begin
      out_data <= pay_item;
    end else if (cmd.emit_hdr) begin
      out_data <= hdr_item;
    end
  end

endmodule

[src/mafs_checker.sv]
// Port-level checker for the MPEG audio frame synchroniser, bound to the top.
// Uses mafs_pkg.
module mafs_checker import mafs_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input out_item_t  out_data
);

  // a stalled request holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output request changed");

  // a blocked output must block the input
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while output held");

  a_header_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind == KIND_HEADER |->
      out_data.layer != 2'd0 && out_data.frame_len != 11'd0
      && out_data.rate_index <= 4'd8 && out_data.last_of_frame == 1'b0)
    else $error("malformed header result");

  a_side_info: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind == KIND_HEADER |->
      (out_data.layer == 2'd3) == (out_data.side_info_len != 6'd0))
    else $error("side info size does not match layer");

  a_payload_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.kind == KIND_PAYLOAD |->
      out_data.header_word == 32'd0 && out_data.frame_len == 11'd0)
    else $error("payload result carries header fields");

endmodule

bind mpeg_audio_frame_sync mafs_checker u_chk (.*);
